// ----- src/seam_energy_map_assert.svh -----
// ----------------------------------------------------------------------------
// seam energy map assertion macros
// shared concurrent assertion forms for the energy map block
// ----------------------------------------------------------------------------
`ifndef SEAM_ENERGY_MAP_ASSERT_SVH
`define SEAM_ENERGY_MAP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SEM_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("seam energy map: same-cycle check failed");

// next-cycle implication, quiet during reset
`define SEM_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("seam energy map: next-cycle check failed");

`endif

// ----- src/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// seam energy map package
// sizes, codes and the word type passed along the term cell chain
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MaxRows     = 1024;
   localparam int RowBits     = $clog2(MaxRows);
   localparam int PixBits     = 24;
   localparam int EnergyBits  = 26;
   localparam int ColBits     = 16;
   localparam int RowsCfgBits = 11;
   localparam int CsrBits     = 16;
   localparam int NumTerms    = 4;
   localparam int NumBanks    = 3;
   localparam int BankBits    = 2;
   localparam int ReqDataBits = ((PixBits + 7) / 8) * 8;
   localparam int RspDataBits = ((EnergyBits + 7) / 8) * 8;

   localparam logic CsrImageColumns = 1'b0;
   localparam logic CsrImageRows    = 1'b1;

   localparam logic KindPixel = 1'b0;
   localparam logic KindFlush = 1'b1;

   // neighbour slots in order left, right, up, down, starting at slot 0
   typedef struct packed {
      logic                              frame_end;
      logic [NumTerms-1:0]               has;
      logic [NumTerms-1:0][PixBits-1:0]  nbr;
      logic [PixBits-1:0]                p;
      logic [EnergyBits-1:0]             acc;
   } sem_word_type;

   function automatic logic [BankBits-1:0] bank_next(input logic [BankBits-1:0] b);
      logic [BankBits-1:0] r;
      r = (b == BankBits'(NumBanks - 1)) ? '0 : b + BankBits'(1);
      return r;
   endfunction

   function automatic logic [BankBits-1:0] bank_prev(input logic [BankBits-1:0] b);
      logic [BankBits-1:0] r;
      r = (b == '0) ? BankBits'(NumBanks - 1) : b - BankBits'(1);
      return r;
   endfunction

endpackage

// ----- src/seam_energy_map.sv -----
// ----------------------------------------------------------------------------
// seam energy map
// four-neighbour absolute difference energy over a column-ordered pixel stream
// ----------------------------------------------------------------------------
// Pixels enter column by column, one word per clock unless the input is held
// off, and each pixel of column c yields the energy of the same row of column
// c-1; after the last column a flush word per row drains the final column,
// the last one flagged by tlast. Every word is accepted with no dead cycles
// between words, columns or frames. A result passes through the registered
// read of the three rotating column stores, then through four term cells
// that each add one neighbour term. The input is held off only when the
// output is stalled and every stage of the chain is full. The column stores
// hold no reset state and need no clearing pass.
// ----------------------------------------------------------------------------
module seam_energy_map
   import sem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,   // pixel_rgb
   input  logic                   req_tuser,   // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,   // energy
   output logic                   rsp_tlast,   // frame_end
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [CsrBits-1:0]     csr_wdata
);

   logic [ColBits-1:0]     cols_ff;
   logic [RowsCfgBits-1:0] rows_ff;

   logic [ColBits-1:0]  col_ff,       col_in;
   logic [RowBits-1:0]  row_ff,       row_in;
   logic [RowBits-1:0]  drain_row_ff, drain_row_in;
   logic                draining_ff,  draining_in;
   logic [BankBits-1:0] bank_ff,      bank_in;

   logic                s0_valid_ff, s0_valid_in;
   logic [BankBits-1:0] s0_ctr_ff,   s0_ctr_in;
   logic [BankBits-1:0] s0_up_ff,    s0_up_in;
   logic [PixBits-1:0]  s0_down_ff;
   logic [PixBits-1:0]  s0_left_ff;
   logic [NumTerms-1:0] s0_has_ff,   s0_has_in;
   logic                s0_end_ff,   s0_end_in;

   logic [RowBits:0]   eff_rows;
   logic [ColBits-1:0] eff_cols;
   logic [RowBits-1:0] cur_row;
   logic               row_last;
   logic               col_last;
   logic               useful;
   logic               accept;
   logic               take;
   logic               en0;

   logic [PixBits-1:0] rd_a [NumBanks];
   logic [PixBits-1:0] rd_b [NumBanks];
   logic [PixBits-1:0] ctr_a;
   logic [PixBits-1:0] ctr_b;
   logic [PixBits-1:0] up_a;

   sem_word_type cell_in;
   logic         cell_valid [NumTerms];
   sem_word_type cell_word  [NumTerms];
   logic         cell_en    [NumTerms];

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= ColBits'(1024);
         rows_ff <= RowsCfgBits'(1024);
      end else if (csr_we) begin
         case (csr_index)
            CsrImageColumns: cols_ff <= csr_wdata[ColBits-1:0];
            CsrImageRows:    rows_ff <= csr_wdata[RowsCfgBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0) begin
         eff_rows = (RowBits+1)'(1);
      end else if (32'(rows_ff) > 32'(MaxRows)) begin
         eff_rows = (RowBits+1)'(MaxRows);
      end else begin
         eff_rows = (RowBits+1)'(rows_ff);
      end
      eff_cols = (cols_ff == '0) ? ColBits'(1) : cols_ff;
   end

   // handshake and enable chain
   always_comb begin
      cell_en[NumTerms-1] = !cell_valid[NumTerms-1] || rsp_tready;
      for (int i = NumTerms - 2; i >= 0; i--) begin
         cell_en[i] = !cell_valid[i] || cell_en[i+1];
      end
      en0 = !s0_valid_ff || cell_en[0];
   end

   assign req_tready = en0;
   assign accept     = req_tvalid && req_tready;
   assign useful     = (req_tuser == KindFlush) ? draining_ff : !draining_ff;
   assign take       = accept && useful;
   assign cur_row    = draining_ff ? drain_row_ff : row_ff;
   assign row_last   = ({1'b0, cur_row} + (RowBits+1)'(1)) >= eff_rows;
   assign col_last   = ({1'b0, col_ff} + (ColBits+1)'(1)) >= {1'b0, eff_cols};

   // frame position and read stage setup
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      drain_row_in = drain_row_ff;
      draining_in  = draining_ff;
      bank_in      = bank_ff;
      s0_valid_in  = 1'b0;
      s0_ctr_in    = s0_ctr_ff;
      s0_up_in     = s0_up_ff;
      s0_has_in    = s0_has_ff;
      s0_end_in    = s0_end_ff;
      if (take) begin
         if (!draining_ff) begin
            s0_valid_in = (col_ff != '0);
            s0_ctr_in   = bank_prev(bank_ff);
            s0_up_in    = bank_next(bank_ff);
            s0_has_in   = {!row_last, row_ff != '0, 1'b1, col_ff > ColBits'(1)};
            s0_end_in   = 1'b0;
            if (row_last) begin
               row_in = '0;
               if (col_last) begin
                  draining_in  = 1'b1;
                  drain_row_in = '0;
               end else begin
                  col_in  = col_ff + ColBits'(1);
                  bank_in = bank_next(bank_ff);
               end
            end else begin
               row_in = row_ff + RowBits'(1);
            end
         end else begin
            s0_valid_in = 1'b1;
            s0_ctr_in   = bank_ff;
            s0_up_in    = bank_prev(bank_ff);
            s0_has_in   = {!row_last, drain_row_ff != '0, 1'b0, col_ff != '0};
            s0_end_in   = row_last;
            if (row_last) begin
               draining_in  = 1'b0;
               col_in       = '0;
               row_in       = '0;
               drain_row_in = '0;
               bank_in      = '0;
            end else begin
               drain_row_in = drain_row_ff + RowBits'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         drain_row_ff <= '0;
         draining_ff  <= 1'b0;
         bank_ff      <= '0;
         s0_valid_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_row_ff <= drain_row_in;
         draining_ff  <= draining_in;
         bank_ff      <= bank_in;
         if (en0) begin
            s0_valid_ff <= s0_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s0_ctr_ff  <= s0_ctr_in;
         s0_up_ff   <= s0_up_in;
         s0_has_ff  <= s0_has_in;
         s0_end_ff  <= s0_end_in;
         s0_down_ff <= req_tdata[PixBits-1:0];
         s0_left_ff <= ctr_a;
      end
   end

   // column stores
   for (genvar i = 0; i < NumBanks; i++) begin : g_bank
      sem_bank u_bank (
         .clock     (clock),
         .wr_en     (take && !draining_ff && (bank_ff == BankBits'(i))),
         .wr_addr   (row_ff),
         .wr_data   (req_tdata[PixBits-1:0]),
         .rd_en     (take),
         .rd_addr_a (cur_row),
         .rd_addr_b (cur_row + RowBits'(1)),
         .rd_data_a (rd_a[i]),
         .rd_data_b (rd_b[i])
      );
   end

   always_comb begin
      case (s0_ctr_ff)
         2'd0:    begin ctr_a = rd_a[0]; ctr_b = rd_b[0]; end
         2'd1:    begin ctr_a = rd_a[1]; ctr_b = rd_b[1]; end
         default: begin ctr_a = rd_a[2]; ctr_b = rd_b[2]; end
      endcase
      case (s0_up_ff)
         2'd0:    up_a = rd_a[0];
         2'd1:    up_a = rd_a[1];
         default: up_a = rd_a[2];
      endcase
      cell_in.frame_end = s0_end_ff;
      cell_in.has       = s0_has_ff;
      cell_in.nbr       = {ctr_b, s0_left_ff, s0_down_ff, up_a};
      cell_in.p         = ctr_a;
      cell_in.acc       = '0;
   end

   // term cell chain
   for (genvar i = 0; i < NumTerms; i++) begin : g_cell
      if (i == 0) begin : g_head
         sem_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (cell_en[i]),
            .in_valid  (s0_valid_ff),
            .in_word   (cell_in),
            .out_valid (cell_valid[i]),
            .out_word  (cell_word[i])
         );
      end else begin : g_tail
         sem_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (cell_en[i]),
            .in_valid  (cell_valid[i-1]),
            .in_word   (cell_word[i-1]),
            .out_valid (cell_valid[i]),
            .out_word  (cell_word[i])
         );
      end
   end

   assign rsp_tvalid = cell_valid[NumTerms-1];
   assign rsp_tdata  = RspDataBits'(cell_word[NumTerms-1].acc);
   assign rsp_tlast  = cell_word[NumTerms-1].frame_end;

`include "seam_energy_map_assert.svh"

   `SEM_ASSERT_NOW(a_drain_row_zero, draining_ff, row_ff == '0)
   `SEM_ASSERT_NEXT(a_frame_wraps, take && draining_ff && row_last, !draining_ff && col_ff == '0)
   `SEM_ASSERT_NEXT(a_pixel_in_drain, accept && draining_ff && req_tuser == KindPixel, draining_ff && $stable(drain_row_ff))

endmodule

// ----- src/sem_bank.sv -----
// ----------------------------------------------------------------------------
// sem bank
// one column store: single write port, two registered read ports
// ----------------------------------------------------------------------------
module sem_bank
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [RowBits-1:0] wr_addr,
   input  logic [PixBits-1:0] wr_data,
   input  logic               rd_en,
   input  logic [RowBits-1:0] rd_addr_a,
   input  logic [RowBits-1:0] rd_addr_b,
   output logic [PixBits-1:0] rd_data_a,
   output logic [PixBits-1:0] rd_data_b
);

   logic [PixBits-1:0] mem_ff [MaxRows];
   logic [PixBits-1:0] rd_a_ff;
   logic [PixBits-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- src/sem_cell.sv -----
// ----------------------------------------------------------------------------
// sem cell
// one term cell: adds the head neighbour term and shifts the rest onward
// ----------------------------------------------------------------------------
module sem_cell
   import sem_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         in_valid,
   input  sem_word_type in_word,
   output logic         out_valid,
   output sem_word_type out_word
);

   logic         valid_ff;
   logic         valid_in;
   sem_word_type word_ff;
   sem_word_type word_in;
   logic [PixBits-1:0] term;

   always_comb begin
      if (!in_word.has[0]) begin
         term = in_word.p;
      end else if (in_word.p > in_word.nbr[0]) begin
         term = in_word.p - in_word.nbr[0];
      end else begin
         term = in_word.nbr[0] - in_word.p;
      end
      word_in           = in_word;
      word_in.acc       = in_word.acc + EnergyBits'(term);
      word_in.has       = {1'b0, in_word.has[NumTerms-1:1]};
      word_in.nbr       = {{PixBits{1'b0}}, in_word.nbr[NumTerms-1:1]};
      valid_in          = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- bench/seam_energy_map_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seam energy map testbench
// column-ordered pixel frames and flush words checked against a local model
// of the neighbor energy sums: a table of border and extreme cases, zero,
// masked and widest register settings, a frame cut short by a column change,
// and random frames with stray words under three sender and receiver stall
// patterns
// ----------------------------------------------------------------------------
module seam_energy_map_test
   import sem_pkg::*;
();

   typedef enum logic {RowWord, RowCsr} row_kind_type;
   typedef enum logic [1:0] {CheckModel, CheckNone, CheckGiven} check_type;

   typedef struct packed {
      logic [EnergyBits-1:0] energy;
      logic                  frame_end;
   } energy_word_type;

   typedef struct packed {
      row_kind_type          what;
      logic                  csr_idx;
      logic [CsrBits-1:0]    csr_val;
      logic                  kind;
      logic [PixBits-1:0]    pix;
      check_type             chk;
      logic [EnergyBits-1:0] energy;
      logic                  last;
   } dir_row_type;

   localparam int DirCount = 24;
   localparam int Settle   = 12;

   localparam dir_row_type DirTable [DirCount] = '{
      // flush right after reset is dropped
      '{RowWord, 1'b0, 16'h0000, KindFlush, 24'h000000, CheckNone, 26'h0, 1'b0},
      // one pixel frames, every neighbor missing
      '{RowCsr, CsrImageColumns, 16'h0000, KindPixel, 24'h0, CheckNone, 26'h0, 1'b0},
      '{RowCsr, CsrImageRows, 16'h0001, KindPixel, 24'h0, CheckNone, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'hFFFFFF, CheckNone, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindFlush, 24'h000000, CheckGiven, 26'h3FFFFFC, 1'b1},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'h000000, CheckNone, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindFlush, 24'hFFFFFF, CheckGiven, 26'h0, 1'b1},
      '{RowWord, 1'b0, 16'h0000, KindFlush, 24'h5A5A5A, CheckNone, 26'h0, 1'b0},
      // 3 x 2 frame, rows written with high bits set
      '{RowCsr, CsrImageRows, 16'hF802, KindPixel, 24'h0, CheckNone, 26'h0, 1'b0},
      '{RowCsr, CsrImageColumns, 16'h0003, KindPixel, 24'h0, CheckNone, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'h123456, CheckModel, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'h000001, CheckModel, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'hFFFFFE, CheckModel, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'h800000, CheckModel, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'h7FFFFF, CheckModel, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'h00FF00, CheckModel, 26'h0, 1'b0},
      // pixel while draining is dropped
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'hABCDEF, CheckNone, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindFlush, 24'h000000, CheckModel, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindFlush, 24'h000000, CheckModel, 26'h0, 1'b0},
      // 2 x 1 frame, black then white
      '{RowCsr, CsrImageColumns, 16'h0002, KindPixel, 24'h0, CheckNone, 26'h0, 1'b0},
      '{RowCsr, CsrImageRows, 16'h0001, KindPixel, 24'h0, CheckNone, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'h000000, CheckNone, 26'h0, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindPixel, 24'hFFFFFF, CheckGiven, 26'h0FFFFFF, 1'b0},
      '{RowWord, 1'b0, 16'h0000, KindFlush, 24'h000000, CheckGiven, 26'h3FFFFFC, 1'b1}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;   // pixel_rgb
   logic                   req_tuser = KindPixel;   // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;   // energy
   logic                   rsp_tlast;   // frame_end
   logic                   csr_we = 1'b0;
   logic                   csr_index = CsrImageColumns;
   logic [CsrBits-1:0]     csr_wdata = '0;

   // model state
   logic [ColBits-1:0]     cfg_cols;
   logic [RowsCfgBits-1:0] cfg_rows;
   int                     col_at;
   int                     row_at;
   int                     drain_at;
   bit                     draining_now;
   logic [PixBits-1:0]     col_mem [NumBanks][MaxRows];

   energy_word_type        pending_energy [$];
   logic [PixBits-1:0]     last_pix = '0;
   int                     send_pct;
   int                     recv_pct;
   int                     fail_count = 0;
   int                     words_sent = 0;
   int                     results_seen = 0;
   int                     frame_words = 0;
   int                     frames_done = 0;

   seam_energy_map uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int rows_in_use();
      int r;
      r = int'(cfg_rows);
      if (r < 1) r = 1;
      if (r > MaxRows) r = MaxRows;
      return r;
   endfunction

   function automatic int cols_in_use();
      return (cfg_cols == '0) ? 1 : int'(cfg_cols);
   endfunction

   function automatic logic [PixBits-1:0] mem_at(int col, int r);
      return (r < MaxRows) ? col_mem[col % NumBanks][r] : '0;
   endfunction

   function automatic logic [EnergyBits-1:0] abs_gap(logic [PixBits-1:0] a,
                                                     logic [PixBits-1:0] b);
      return EnergyBits'((a > b) ? a - b : b - a);
   endfunction

   function automatic logic [EnergyBits-1:0] pixel_energy(int col, int r, bit has_down,
         logic [PixBits-1:0] down_pix, int rows);
      logic [PixBits-1:0]    p;
      logic [EnergyBits-1:0] e;
      p = mem_at(col, r);
      e = (col > 0) ? abs_gap(p, mem_at(col - 1, r)) : EnergyBits'(p);
      e = e + (has_down ? abs_gap(p, down_pix) : EnergyBits'(p));
      e = e + ((r > 0) ? abs_gap(p, mem_at(col, r - 1)) : EnergyBits'(p));
      e = e + ((r + 1 < rows) ? abs_gap(p, mem_at(col, r + 1)) : EnergyBits'(p));
      return e;
   endfunction

   // advances the model by one accepted word, returns 1 when it yields a result
   function automatic bit energy_step(logic kind, logic [PixBits-1:0] pix,
                                      output energy_word_type res);
      int rows;
      int cols;
      bit hit;
      rows = rows_in_use();
      cols = cols_in_use();
      hit = 1'b0;
      res = '0;
      if (kind == KindPixel) begin
         if (!draining_now) begin
            if (col_at > 0) begin
               res.energy = pixel_energy(col_at - 1, row_at, 1'b1, pix, rows);
               hit = 1'b1;
            end
            if (row_at < MaxRows) col_mem[col_at % NumBanks][row_at] = pix;
            if (row_at + 1 >= rows) begin
               row_at = 0;
               if (col_at + 1 >= cols) begin
                  draining_now = 1'b1;
                  drain_at = 0;
               end else begin
                  col_at = (col_at + 1) & 32'hFFFF;
               end
            end else begin
               row_at = row_at + 1;
            end
         end
      end else if (draining_now) begin
         res.energy = pixel_energy(col_at, drain_at, 1'b0, '0, rows);
         res.frame_end = (drain_at + 1 >= rows);
         hit = 1'b1;
         if (res.frame_end) begin
            draining_now = 1'b0;
            col_at = 0;
            row_at = 0;
            drain_at = 0;
         end else begin
            drain_at = drain_at + 1;
         end
      end
      return hit;
   endfunction

   function automatic logic [PixBits-1:0] rand_pixel();
      case ($urandom_range(7))
         0: last_pix = '0;
         1: last_pix = '1;
         2: last_pix = last_pix + PixBits'($urandom_range(15)) - PixBits'(8);
         default: last_pix = PixBits'($urandom);
      endcase
      return last_pix;
   endfunction

   task automatic send_word(logic kind, logic [PixBits-1:0] pix, check_type chk,
                            energy_word_type given);
      int              gap;
      bit              hit;
      energy_word_type res;
      gap = 0;
      while (gap < 8 && $urandom_range(99) < send_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      hit = energy_step(kind, pix, res);
      if (chk == CheckGiven) pending_energy.push_back(given);
      else if (chk == CheckModel && hit) pending_energy.push_back(res);
   endtask

   // stop sending and let every expected word and the pipeline drain
   task automatic drain_wait();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_energy.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [CsrBits-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CsrImageColumns) cfg_cols = data;
      else cfg_rows = data[RowsCfgBits-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one frame: pixels until the model drains, then flushes, with stray words
   task automatic run_frame(bit cut_ok);
      bit              cut_done;
      energy_word_type none;
      cut_done = 1'b0;
      none = '0;
      while (!draining_now) begin
         if (cut_ok && !cut_done && row_at == 0 && col_at > 0 &&
               ($urandom_range(3) == 0 || col_at >= 8)) begin
            drain_wait();
            csr_write(CsrImageColumns, CsrBits'($urandom_range(0, col_at + 1)));
            cut_done = 1'b1;
         end
         if ($urandom_range(19) == 0) send_word(KindFlush, rand_pixel(), CheckModel, none);
         send_word(KindPixel, rand_pixel(), CheckModel, none);
         frame_words++;
      end
      while (draining_now) begin
         if ($urandom_range(19) == 0) send_word(KindPixel, rand_pixel(), CheckModel, none);
         send_word(KindFlush, rand_pixel(), CheckModel, none);
         frame_words++;
      end
      frames_done++;
   endtask

   task automatic random_phase(int target);
      int start;
      int cols;
      int rows;
      start = frame_words;
      while (frame_words - start < target) begin
         if ($urandom_range(1) == 0) begin
            drain_wait();
            case ($urandom_range(9))
               0: rows = $urandom_range(11, 40);
               1: rows = 0;
               default: rows = $urandom_range(1, 10);
            endcase
            cols = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            csr_write(CsrImageRows, {5'($urandom), 11'(rows)});
            csr_write(CsrImageColumns, CsrBits'(cols));
         end
         run_frame(cols_in_use() >= 3 && $urandom_range(5) == 0);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_pct);
   end

   always @(posedge clock) begin
      energy_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_energy.size() == 0) begin
            $error("unexpected result word: energy %0h, frame_end %0b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = pending_energy.pop_front();
            if (rsp_tdata !== RspDataBits'(want.energy)) begin
               $error("energy: expected %0h, actual %0h", want.energy, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $error("frame_end: expected %0b, actual %0b", want.frame_end, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("seam_energy_map_test NOT OK");
      $finish;
   end

   initial begin
      energy_word_type given;
      cfg_cols = ColBits'(1024);
      cfg_rows = RowsCfgBits'(1024);
      col_at = 0;
      row_at = 0;
      drain_at = 0;
      draining_now = 1'b0;
      for (int b = 0; b < NumBanks; b++) begin
         for (int r = 0; r < MaxRows; r++) col_mem[b][r] = '0;
      end
      send_pct = 27;
      recv_pct = 68;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DirCount; i++) begin
         if (DirTable[i].what == RowCsr) begin
            drain_wait();
            csr_write(DirTable[i].csr_idx, DirTable[i].csr_val);
         end else begin
            given.energy = DirTable[i].energy;
            given.frame_end = DirTable[i].last;
            send_word(DirTable[i].kind, DirTable[i].pix, DirTable[i].chk, given);
         end
      end

      // widest column count, cut short mid-frame
      drain_wait();
      csr_write(CsrImageColumns, 16'hFFFF);
      csr_write(CsrImageRows, 16'h0003);
      run_frame(1'b1);
      // rows masked down to zero, acting as one
      drain_wait();
      csr_write(CsrImageColumns, 16'h0005);
      csr_write(CsrImageRows, 16'h0800);
      run_frame(1'b0);

      random_phase(450);
      send_pct = 68;
      recv_pct = 27;
      random_phase(450);
      send_pct = 0;
      recv_pct = 0;
      random_phase(450);
      drain_wait();

      $display("ran %0d frames: %0d stream words sent, %0d energy words checked",
               frames_done, words_sent, results_seen);
      $display("covered one pixel frames, zero and masked registers, the widest column count");
      if (fail_count == 0) begin
         $display("seam_energy_map_test OK");
      end else begin
         $display("seam_energy_map_test NOT OK");
      end
      $finish;
   end

endmodule
